[sv/t3nr_pkg.sv]
// ---------------------------------------------------------------------------
// t3nr_pkg: shared constants for the 3D torus neighbour rank block
// Field widths, register indices and cell modes.
// ---------------------------------------------------------------------------
package t3nr_pkg;

    localparam int RANK_W  = 21;
    localparam int COORD_W = 7;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 2;
    localparam int MAX_DIM_DEFAULT = 128;

    // configuration register indices
    localparam logic [IDX_W-1:0] REG_DIM_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_DIM_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_DIM_Z = 2'd2;

    localparam logic [CFG_W-1:0] DIM_RESET = 8'd1;

    // cell modes
    localparam int CELL_PASS = 0;
    localparam int CELL_Z    = 1;
    localparam int CELL_Y    = 2;

endpackage

[sv/t3nr_cell.sv]
// ---------------------------------------------------------------------------
// t3nr_cell: one restoring-division cell
// Resolves one quotient bit (z or y) per stage, or just registers the item.
// ---------------------------------------------------------------------------
module t3nr_cell #(
    parameter int DW   = 8,
    parameter int PW   = 16,
    parameter int RW   = t3nr_pkg::RANK_W,
    parameter int MODE = t3nr_pkg::CELL_PASS,
    parameter int BIT  = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [RW-1:0] in_rank,
    input  logic [RW-1:0] in_rem,
    input  logic [DW-1:0] in_zq,
    input  logic [DW-1:0] in_yq,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [RW-1:0] out_rank,
    output logic [RW-1:0] out_rem,
    output logic [DW-1:0] out_zq,
    output logic [DW-1:0] out_yq,
    input  logic [DW-1:0] dx,
    input  logic [PW-1:0] plane
);

    localparam int KW = (RW > PW + DW) ? RW : PW + DW;

    logic          v_reg;
    logic [RW-1:0] rank_reg, rem_reg, rem_next;
    logic [DW-1:0] zq_reg, zq_next, yq_reg, yq_next;
    logic [KW-1:0] cand;
    logic          ge;

    assign in_ready = !v_reg || out_ready;

    always_comb
    begin
        cand = '0;
        if (MODE == t3nr_pkg::CELL_Z)
        begin
            cand = KW'(plane) << BIT;
        end
        else if (MODE == t3nr_pkg::CELL_Y)
        begin
            cand = KW'(dx) << BIT;
        end
        ge       = (MODE != t3nr_pkg::CELL_PASS) && (KW'(in_rem) >= cand);
        rem_next = ge ? RW'(KW'(in_rem) - cand) : in_rem;
        zq_next  = in_zq;
        yq_next  = in_yq;
        if (MODE == t3nr_pkg::CELL_Z)
        begin
            zq_next[BIT] = ge;
        end
        else if (MODE == t3nr_pkg::CELL_Y)
        begin
            yq_next[BIT] = ge;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rank_reg <= in_rank;
            rem_reg  <= rem_next;
            zq_reg   <= zq_next;
            yq_reg   <= yq_next;
        end
    end

    assign out_valid = v_reg;
    assign out_rank  = rank_reg;
    assign out_rem   = rem_reg;
    assign out_zq    = zq_reg;
    assign out_yq    = yq_reg;

endmodule

[sv/t3nr_nbr.sv]
// ---------------------------------------------------------------------------
// t3nr_nbr: neighbour rank stage
// Forms wrapped neighbour ranks and the range flag; holds the output register.
// ---------------------------------------------------------------------------
module t3nr_nbr #(
    parameter int DW = 8,
    parameter int PW = 16,
    parameter int TW = 24,
    parameter int RW = t3nr_pkg::RANK_W,
    parameter int CW = t3nr_pkg::COORD_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [RW-1:0] in_rank,
    input  logic [RW-1:0] in_x,
    input  logic [DW-1:0] in_y,
    input  logic [DW-1:0] in_z,
    input  logic [DW-1:0] dx,
    input  logic [DW-1:0] dy,
    input  logic [DW-1:0] dz,
    input  logic [PW-1:0] plane,
    input  logic [TW-1:0] total,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [CW-1:0] coord_x,
    output logic [CW-1:0] coord_y,
    output logic [CW-1:0] coord_z,
    output logic [RW-1:0] east_rank,
    output logic [RW-1:0] west_rank,
    output logic [RW-1:0] north_rank,
    output logic [RW-1:0] south_rank,
    output logic [RW-1:0] up_rank,
    output logic [RW-1:0] down_rank,
    output logic          rank_error
);

    localparam int EW = (RW > TW) ? RW : TW;

    logic          v_reg;
    logic          err;
    logic [RW-1:0] dxm, pl, tt, pmx, tmp;
    logic [CW-1:0] cx_next, cy_next, cz_next;
    logic [RW-1:0] e_next, w_next, n_next, s_next, u_next, d_next;
    logic [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic [RW-1:0] e_reg, w_reg, n_reg, s_reg, u_reg, d_reg;
    logic          err_reg;

    assign in_ready = !v_reg || out_ready;

    always_comb
    begin
        err = EW'(in_rank) >= EW'(total);
        dxm = RW'(dx) - RW'(1);
        pl  = RW'(plane);
        tt  = RW'(total);
        pmx = pl - RW'(dx);
        tmp = tt - pl;
        // wrap terms taken modulo 2^RW, as the rank field is
        e_next = (in_x == dxm) ? in_rank - dxm : in_rank + RW'(1);
        w_next = (in_x == '0) ? in_rank + dxm : in_rank - RW'(1);
        n_next = (in_y == dy - DW'(1)) ? in_rank - pmx : in_rank + RW'(dx);
        s_next = (in_y == '0) ? in_rank + pmx : in_rank - RW'(dx);
        u_next = (in_z == dz - DW'(1)) ? in_rank - tmp : in_rank + pl;
        d_next = (in_z == '0) ? in_rank + tmp : in_rank - pl;
        cx_next = CW'(in_x);
        cy_next = CW'(in_y);
        cz_next = CW'(in_z);
        if (err)
        begin
            cx_next = '0;
            cy_next = '0;
            cz_next = '0;
            e_next  = '0;
            w_next  = '0;
            n_next  = '0;
            s_next  = '0;
            u_next  = '0;
            d_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            cz_reg  <= cz_next;
            e_reg   <= e_next;
            w_reg   <= w_next;
            n_reg   <= n_next;
            s_reg   <= s_next;
            u_reg   <= u_next;
            d_reg   <= d_next;
            err_reg <= err;
        end
    end

    assign out_valid  = v_reg;
    assign coord_x    = cx_reg;
    assign coord_y    = cy_reg;
    assign coord_z    = cz_reg;
    assign east_rank  = e_reg;
    assign west_rank  = w_reg;
    assign north_rank = n_reg;
    assign south_rank = s_reg;
    assign up_rank    = u_reg;
    assign down_rank  = d_reg;
    assign rank_error = err_reg;

endmodule

[sv/torus_3d_neighbor_rank.sv]
// ---------------------------------------------------------------------------
// torus_3d_neighbor_rank: 3D torus coordinate and neighbour lookup
// Splits a node rank into x/y/z (x fastest) and returns six wrapped
// neighbour ranks plus an out-of-range flag.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries node_rank; output channel
//   out_valid/out_ready carries coordinates, neighbour ranks and rank_error.
//   One transfer per cycle on each side when the receiver keeps up.
//   The division chain holds one input cell, DW cells for z and DW cells
//   for y (DW = bits of MAX_DIM, 8 at the default), followed by the
//   neighbour/output stage.
//   Each cell has its own valid flag; a stalled receiver holds the output
//   register and bubbles still close up, so in_ready only drops when every
//   stage is full.
//   Sizes are written on cfg_we/cfg_index/cfg_wdata while no item is in
//   flight. Zero reads as 1, values above MAX_DIM saturate.
//   Reset: all sizes to 1, pipeline empty.
//   An out-of-range rank gives rank_error = 1 with all other fields zero.
// ---------------------------------------------------------------------------
module torus_3d_neighbor_rank #(
    parameter int MAX_DIM = t3nr_pkg::MAX_DIM_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [t3nr_pkg::IDX_W-1:0]     cfg_index,
    input  logic [t3nr_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [t3nr_pkg::RANK_W-1:0]    node_rank,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [t3nr_pkg::COORD_W-1:0]   coord_x,
    output logic [t3nr_pkg::COORD_W-1:0]   coord_y,
    output logic [t3nr_pkg::COORD_W-1:0]   coord_z,
    output logic [t3nr_pkg::RANK_W-1:0]    east_rank,
    output logic [t3nr_pkg::RANK_W-1:0]    west_rank,
    output logic [t3nr_pkg::RANK_W-1:0]    north_rank,
    output logic [t3nr_pkg::RANK_W-1:0]    south_rank,
    output logic [t3nr_pkg::RANK_W-1:0]    up_rank,
    output logic [t3nr_pkg::RANK_W-1:0]    down_rank,
    output logic                           rank_error
);

    localparam int RW = t3nr_pkg::RANK_W;
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int PW = 2 * DW;
    localparam int TW = 3 * DW;
    localparam int EW = (DW > t3nr_pkg::CFG_W) ? DW : t3nr_pkg::CFG_W;
    localparam int NC = 1 + 2 * DW;   // cells in the chain

    // size registers
    logic [t3nr_pkg::CFG_W-1:0] dim_x_reg, dim_y_reg, dim_z_reg;
    logic [DW-1:0] dx, dy, dz;
    logic [PW-1:0] plane_reg;
    logic [TW-1:0] total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg <= t3nr_pkg::DIM_RESET;
            dim_y_reg <= t3nr_pkg::DIM_RESET;
            dim_z_reg <= t3nr_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                t3nr_pkg::REG_DIM_X: dim_x_reg <= cfg_wdata;
                t3nr_pkg::REG_DIM_Y: dim_y_reg <= cfg_wdata;
                t3nr_pkg::REG_DIM_Z: dim_z_reg <= cfg_wdata;
                default: ;   // no register there
            endcase
        end
    end

    // effective size: zero counts as one, large values clamp to MAX_DIM
    function automatic logic [DW-1:0] eff_dim(input logic [t3nr_pkg::CFG_W-1:0] d);
        logic [EW-1:0] w;
        w = EW'(d);
        if (w == '0)
            return DW'(1);
        else if (w > EW'(MAX_DIM))
            return DW'(MAX_DIM);
        else
            return DW'(w);
    endfunction

    assign dx = eff_dim(dim_x_reg);
    assign dy = eff_dim(dim_y_reg);
    assign dz = eff_dim(dim_z_reg);

    // products recomputed every cycle; the input cell covers their first
    // cycle after a write, and total is only used at the end of the chain
    always_ff @(posedge clk)
    begin
        plane_reg <= PW'(dx) * PW'(dy);
        total_reg <= TW'(plane_reg) * TW'(dz);
    end

    // division chain
    logic          c_valid [NC+1];
    logic          c_ready [NC+1];
    logic [RW-1:0] c_rank  [NC+1];
    logic [RW-1:0] c_rem   [NC+1];
    logic [DW-1:0] c_zq    [NC+1];
    logic [DW-1:0] c_yq    [NC+1];

    assign c_valid[0] = in_valid;
    assign in_ready   = c_ready[0];
    assign c_rank[0]  = node_rank;
    assign c_rem[0]   = node_rank;
    assign c_zq[0]    = '0;
    assign c_yq[0]    = '0;

    genvar i;
    generate
        for (i = 0; i < NC; i++)
        begin : g_cell
            localparam int MODE = (i == 0) ? t3nr_pkg::CELL_PASS :
                                  (i <= DW) ? t3nr_pkg::CELL_Z : t3nr_pkg::CELL_Y;
            localparam int BIT  = (i == 0) ? 0 : (i <= DW) ? DW - i : 2 * DW - i;
            t3nr_cell #(
                .DW   (DW),
                .PW   (PW),
                .RW   (RW),
                .MODE (MODE),
                .BIT  (BIT)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (c_valid[i]),
                .in_ready  (c_ready[i]),
                .in_rank   (c_rank[i]),
                .in_rem    (c_rem[i]),
                .in_zq     (c_zq[i]),
                .in_yq     (c_yq[i]),
                .out_valid (c_valid[i+1]),
                .out_ready (c_ready[i+1]),
                .out_rank  (c_rank[i+1]),
                .out_rem   (c_rem[i+1]),
                .out_zq    (c_zq[i+1]),
                .out_yq    (c_yq[i+1]),
                .dx        (dx),
                .plane     (plane_reg)
            );
        end
    endgenerate

    // remainder after both divisions is x
    t3nr_nbr #(
        .DW (DW),
        .PW (PW),
        .TW (TW),
        .RW (RW),
        .CW (t3nr_pkg::COORD_W)
    ) u_nbr (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (c_valid[NC]),
        .in_ready   (c_ready[NC]),
        .in_rank    (c_rank[NC]),
        .in_x       (c_rem[NC]),
        .in_y       (c_yq[NC]),
        .in_z       (c_zq[NC]),
        .dx         (dx),
        .dy         (dy),
        .dz         (dz),
        .plane      (plane_reg),
        .total      (total_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .east_rank  (east_rank),
        .west_rank  (west_rank),
        .north_rank (north_rank),
        .south_rank (south_rank),
        .up_rank    (up_rank),
        .down_rank  (down_rank),
        .rank_error (rank_error)
    );

    // back-pressure only reaches the input once the output is held
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled with output not blocked");

    // an error result carries nothing else
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rank_error) |-> (coord_x == '0 && east_rank == '0 &&
                                       up_rank == '0 && down_rank == '0))
        else $error("error result with non-zero fields");

    // a held result does not change under the receiver's stall
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(east_rank) &&
                                        $stable(rank_error)))
        else $error("stalled result changed");

endmodule
